>>> rtl/slid_pkg.sv
// Package with shared types and constants of the sorted list insert/delete unit.
`timescale 1ns / 1ps
`default_nettype none

package slid_pkg;

	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 5;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_DELETE = 1'b1
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic                      ins_en;
		logic                      del_en;
		logic signed [VALUE_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic lt;
		logic bnd;
		logic hit;
	} cell_flag_t;

endpackage

`default_nettype wire

>>> rtl/slid_if.sv
// Interfaces of the request and response channels.
`timescale 1ns / 1ps
`default_nettype none

interface slid_req_if;
	logic                               valid;
	logic                               ready;
	slid_pkg::func_t                    func;
	logic signed [slid_pkg::VALUE_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface slid_rsp_if;
	logic                          valid;
	logic                          ready;
	slid_pkg::status_t             status;
	logic [slid_pkg::COUNT_W-1:0]  entry_count;
	logic [slid_pkg::POS_W-1:0]    position;

	modport source (output valid, output status, output entry_count, output position,
		input ready);
	modport sink (input valid, input status, input entry_count, input position,
		output ready);
endinterface

`default_nettype wire

>>> rtl/slid_cell.sv
// One storage cell of the sorted row: compares its entry and shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module slid_cell #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  wire logic                                clk,
	input  wire slid_pkg::cell_cmd_t                 cmd,
	input  wire logic [CNT_W-1:0]                    count,
	input  wire logic                                lt_prev,
	input  wire logic signed [slid_pkg::VALUE_W-1:0] entry_prev,
	input  wire logic signed [slid_pkg::VALUE_W-1:0] entry_next,
	output logic signed [slid_pkg::VALUE_W-1:0]      entry,
	output slid_pkg::cell_flag_t                     flag
);

	logic signed [slid_pkg::VALUE_W-1:0] entry_q;
	logic                                occupied;

	assign occupied = count > CNT_W'(IDX);
	assign entry    = entry_q;

	always_comb begin
		flag.lt  = occupied && (entry_q < cmd.value);
		flag.bnd = lt_prev && !flag.lt;
		flag.hit = flag.bnd && occupied && (entry_q == cmd.value);
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !flag.lt) begin
			entry_q <= flag.bnd ? cmd.value : entry_prev;
		end else if (cmd.del_en && !flag.lt) begin
			entry_q <= entry_next;
		end
	end

endmodule

`default_nettype wire

>>> rtl/sorted_list_insert_delete_unit.sv
// Top level of the sorted list insert/delete unit: request stage, cell row and response register.
// The unit keeps up to CAPACITY signed values in ascending order in a row of cells. A request
// beat is registered in the request stage; every cell then compares the value with its own
// entry, and the cells from the insert or delete position onward shift by one place when the
// operation is carried out, and the response is then offered from the response register. One
// request per clock is sustained while responses are taken; the rate is set by the single
// compare-and-shift step of the cell row. An insert into a full store is dropped with status
// full, and a delete that finds no equal entry reports not-found. Entry count and position
// give the low bits of the true values when CAPACITY is large.
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_insert_delete_unit #(
	parameter int CAPACITY = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	slid_req_if.sink   req,
	slid_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);

	logic                                valid_s1;
	slid_pkg::func_t                     func_s1;
	logic signed [slid_pkg::VALUE_W-1:0] value_s1;

	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	slid_pkg::status_t status_q;
	logic [slid_pkg::COUNT_W-1:0] entry_count_q;
	logic [slid_pkg::POS_W-1:0]   position_q;

	logic advance;
	logic do_op;
	logic full;
	logic found;
	logic [IDX_W-1:0] pos_idx;
	logic [CNT_W-1:0] count_next;
	slid_pkg::status_t status_next;

	slid_pkg::cell_cmd_t  cmd;
	slid_pkg::cell_flag_t flags [CAPACITY];
	logic signed [slid_pkg::VALUE_W-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] bnd_vec;
	logic [CAPACITY-1:0] hit_vec;

	assign advance   = !rsp_valid_q || rsp.ready;
	assign do_op     = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;
	assign full      = count_q == CNT_W'(CAPACITY);
	assign found     = |hit_vec;

	assign cmd.ins_en = do_op && (func_s1 == slid_pkg::FUNC_INSERT) && !full;
	assign cmd.del_en = do_op && (func_s1 == slid_pkg::FUNC_DELETE) && found;
	assign cmd.value  = value_s1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		slid_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.lt_prev    ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]),
			.entry_prev ((i == 0) ? value_s1 : entries[(i == 0) ? 0 : i - 1]),
			.entry_next ((i == CAPACITY - 1) ? entries[i]
				: entries[(i == CAPACITY - 1) ? i : i + 1]),
			.entry      (entries[i]),
			.flag       (flags[i])
		);
		assign lt_vec[i]  = flags[i].lt;
		assign bnd_vec[i] = flags[i].bnd;
		assign hit_vec[i] = flags[i].hit;
	end

	always_comb begin
		pos_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pos_idx = pos_idx | (bnd_vec[i] ? IDX_W'(i) : '0);
		end
	end

	always_comb begin
		count_next  = count_q;
		status_next = slid_pkg::ST_DONE;
		if (func_s1 == slid_pkg::FUNC_INSERT) begin
			if (full) begin
				status_next = slid_pkg::ST_FULL;
			end else begin
				count_next = count_q + CNT_W'(1);
			end
		end else begin
			if (found) begin
				count_next = count_q - CNT_W'(1);
			end else begin
				status_next = slid_pkg::ST_NOT_FOUND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (do_op) begin
				rsp_valid_q <= 1'b1;
				count_q     <= count_next;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1  <= req.func;
			value_s1 <= req.value;
		end
		if (do_op) begin
			status_q      <= status_next;
			entry_count_q <= slid_pkg::COUNT_W'(count_next);
			position_q    <= (status_next == slid_pkg::ST_DONE)
				? slid_pkg::POS_W'(pos_idx) : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.position    = position_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("Stored count exceeds the capacity.");

	a_hit_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec) && $onehot0(bnd_vec))
		else $error("More than one cell claims the insert or delete position.");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(do_op && func_s1 == slid_pkg::FUNC_INSERT && full)
		|=> (rsp.valid && rsp.status == slid_pkg::ST_FULL && $stable(count_q)))
		else $error("Insert into a full store was not dropped.");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(do_op && func_s1 == slid_pkg::FUNC_DELETE && found)
		|=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("Successful delete did not decrement the count.");

endmodule

`default_nettype wire
